[design/ali_pkg.sv]
// Shared types and codes for the array list block.
package ali_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BADPOS   = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_SHIFT  = 6'b000100,
    ST_PUT    = 6'b001000,
    ST_RDWAIT = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 8;
  localparam int unsigned CntOutW = 8;

endpackage

[design/ali_req_if.sv]
// Request channel interface of the array list block.
interface ali_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input value,
                  output ready);
endinterface

[design/ali_rsp_if.sv]
// Response channel interface of the array list block.
interface ali_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [7:0]         count_after;

  modport source (output valid, output status, output read_value, output count_after,
                  input ready);
  modport sink   (input valid, input status, input read_value, input count_after,
                  output ready);
endinterface

[design/ali_ram.sv]
// List storage: one write port, one read port with registered read data.
module ali_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/array_list_insert_delete.sv]
// Fixed-capacity list of signed 32-bit values: clear, insert at position, delete by value,
// read at position. The list lives in a single-port-write, single-port-read memory and every
// request is worked by a small sequencer that moves one entry per cycle, so the block takes one
// transaction at a time. A read waits for the registered memory data; an insert shifts the
// entries from position p up one slot and then writes the value; a delete searches from index
// 0 for the first matching entry and then shifts the later entries down one slot. No clearing
// pass is needed after reset. A finished result sits in an output register, so the next
// request is taken while it waits.
module array_list_insert_delete
  import ali_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ali_req_if.sink    req_i,
  ali_rsp_if.source  rsp_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMPW = ((CW > PosW) ? CW : PosW) + 1;

  state_e            state_q, state_d;
  req_e              op_q, op_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  logic              cmp_v_q, cmp_v_d;
  logic [CW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]     put_addr_q, put_addr_d;
  logic [DataW-1:0]  val_q, val_d;
  status_e           st_q, st_d;
  logic [DataW-1:0]  rd_q, rd_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_status_q;
  logic [DataW-1:0]  out_rdata_q;
  logic [CntOutW-1:0] out_cnt_q;
  logic              out_load;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DataW-1:0]  mem_wdata, mem_rdata;

  logic              accept;
  logic [CMPW-1:0]   pos_x, cnt_x;
  logic [CMPW-1:0]   pos_m1;
  logic              ins_bad, rd_bad;
  logic [CW+CntOutW-1:0] cnt_ext;

  ali_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign pos_x   = CMPW'(req_i.position);
  assign cnt_x   = CMPW'(cnt_q);
  assign pos_m1  = pos_x - CMPW'(1);
  assign ins_bad = (req_i.position == '0) || (pos_x > cnt_x + CMPW'(1));
  assign rd_bad  = (req_i.position == '0) || (pos_x > cnt_x);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    cmp_v_d     = cmp_v_q;
    cmp_idx_d   = cmp_idx_q;
    put_addr_d  = put_addr_q;
    val_d       = val_q;
    st_d        = st_q;
    rd_d        = rd_q;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pend_addr_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = idx_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d      = req_i.value;
          put_addr_d = pos_m1[AW-1:0];
          rd_d       = '0;
          op_d       = req_e'(req_i.req_type);
          pend_d     = 1'b0;
          cmp_v_d    = 1'b0;
          case (req_e'(req_i.req_type))
            REQ_CLEAR: begin
              cnt_d   = '0;
              st_d    = STAT_OK;
              state_d = ST_DONE;
            end
            REQ_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                st_d    = STAT_FULL;
                state_d = ST_DONE;
              end else if (ins_bad) begin
                st_d    = STAT_BADPOS;
                state_d = ST_DONE;
              end else begin
                idx_d   = cnt_q - CW'(1);
                rem_d   = CW'(cnt_x - pos_m1);
                state_d = ST_SHIFT;
              end
            end
            REQ_DELETE: begin
              if (cnt_q == '0) begin
                st_d    = STAT_NOTFOUND;
                state_d = ST_DONE;
              end else begin
                idx_d   = '0;
                state_d = ST_SEARCH;
              end
            end
            REQ_READ: begin
              if (rd_bad) begin
                st_d    = STAT_BADPOS;
                state_d = ST_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_m1[AW-1:0];
                state_d   = ST_RDWAIT;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        if (cmp_v_q && (mem_rdata == val_q)) begin
          idx_d   = cmp_idx_q + CW'(1);
          rem_d   = cnt_q - CW'(1) - cmp_idx_q;
          cmp_v_d = 1'b0;
          pend_d  = 1'b0;
          state_d = ST_SHIFT;
        end else if (cmp_v_q && (cmp_idx_q == cnt_q - CW'(1))) begin
          cmp_v_d = 1'b0;
          st_d    = STAT_NOTFOUND;
          state_d = ST_DONE;
        end else if (idx_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[AW-1:0];
          cmp_v_d   = 1'b1;
          cmp_idx_d = idx_q;
          idx_d     = idx_q + CW'(1);
        end else begin
          cmp_v_d = 1'b0;
        end
      end

      // one entry moved per cycle: read at idx, write the previous read one slot over
      ST_SHIFT: begin
        if (pend_q) begin
          mem_we = 1'b1;
        end
        if (rem_q != '0) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          rem_d  = rem_q - CW'(1);
          if (op_q == REQ_INSERT) begin
            pend_addr_d = AW'(idx_q + CW'(1));
            idx_d       = idx_q - CW'(1);
          end else begin
            pend_addr_d = AW'(idx_q - CW'(1));
            idx_d       = idx_q + CW'(1);
          end
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (op_q == REQ_INSERT) begin
              state_d = ST_PUT;
            end else begin
              cnt_d   = cnt_q - CW'(1);
              st_d    = STAT_OK;
              state_d = ST_DONE;
            end
          end
        end
      end

      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = put_addr_q;
        mem_wdata = val_q;
        cnt_d     = cnt_q + CW'(1);
        st_d      = STAT_OK;
        state_d   = ST_DONE;
      end

      ST_RDWAIT: begin
        rd_d    = mem_rdata;
        st_d    = STAT_OK;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign cnt_ext = {{CntOutW{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    idx_q       <= idx_d;
    rem_q       <= rem_d;
    pend_addr_q <= pend_addr_d;
    cmp_idx_q   <= cmp_idx_d;
    put_addr_q  <= put_addr_d;
    val_q       <= val_d;
    st_q        <= st_d;
    rd_q        <= rd_d;
    if (out_load) begin
      out_status_q <= st_q;
      out_rdata_q  <= rd_q;
      out_cnt_q    <= cnt_ext[CntOutW-1:0];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.read_value  = out_rdata_q;
  assign rsp_o.count_after = out_cnt_q;

endmodule
